[hw/rtl/dtc_pkg.sv]
// Package for the domino tiling counter: widths, saturation limit,
// controller/datapath command and status structs, even-run check function.
// No dependencies.
`timescale 1ns / 1ps

package dtc_pkg;

	// default board limits
	localparam int DTC_MAX_ROWS = 11;
	localparam int DTC_MAX_COLS = 16;

	// width of the even-run check, the largest mask the design supports
	localparam int EVEN_W = 12;

	// tiling counts are kept saturated below 2^63
	localparam int CNT_W = 63;
	localparam logic [CNT_W-1:0] SAT_MAX = {CNT_W{1'b1}};

	// controller to datapath commands
	typedef struct packed {
		logic start;     // latch a new request, clear the query state
		logic issue;     // walk one mask pair and read its count
		logic next_col;  // step to the next column, swap count banks
		logic load_out;  // move the finished count into the output register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic cols_zero; // request at the input has zero width
		logic b_zero;    // current source mask is the empty mask
		logic a_last;    // current target mask is the full mask
		logic col_last;  // current column is the last one
		logic out_full;  // output register holds an unaccepted result
	} sts_t;

	// true when every run of zero bits of m inside the set bits of full is even
	function automatic logic even_runs(input logic [EVEN_W-1:0] m,
		input logic [EVEN_W-1:0] full);
		logic [EVEN_W-1:0] pad;
		logic odd;
		logic fail;
		pad  = m | ~full;
		odd  = 1'b0;
		fail = 1'b0;
		for (int i = 0; i < EVEN_W; i++) begin
			if (pad[i]) begin
				fail = fail | odd;
				odd  = 1'b0;
			end else begin
				odd = ~odd;
			end
		end
		return ~(fail | odd);
	endfunction

endpackage

[hw/rtl/domino_tiling_counter_core.sv]
// Domino tiling counter: number of 1x2 domino tilings of a rows x cols board
// by the column-by-column bitmask dynamic program.
// Input channel in_valid/in_ready carries rows and cols; one request at a time.
// Output channel out_valid/out_ready carries tilings and overflow, one result
// per request; counts saturate at 2^63-1 and then overflow is set.
// Each pair of disjoint masks is walked in turn and needs one read of the
// previous column's counts from the single read port of the bank being read;
// 3^rows pairs make one column, followed by a drain state that writes back
// the last count of the column and swaps banks.
// Zero width skips the column walk. rows above MAX_ROWS and cols above
// MAX_COLS are clamped.
// Requests do not overlap; the next one is taken the cycle after
// the previous count has been loaded into the output register.
// The result sits in an output register: a new request is taken while it
// waits, and a finished count is held in the done state if the receiver stalls.
// Reset clears the controller and the output valid; the count memories need
// no clearing since every entry is written before its value is used.
// Depends on dtc_pkg, dtc_ctrl, dtc_datapath, dtc_ram.
`timescale 1ns / 1ps

module domino_tiling_counter_core #(
	parameter int MAX_ROWS = dtc_pkg::DTC_MAX_ROWS,
	parameter int MAX_COLS = dtc_pkg::DTC_MAX_COLS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [3:0]                rows,
	input  logic [4:0]                cols,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [dtc_pkg::CNT_W-1:0] tilings,
	output logic                      overflow
);
	import dtc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	dtc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// counters, count banks and result
	dtc_datapath #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.rows     (rows),
		.cols     (cols),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.tilings  (tilings),
		.overflow (overflow),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

[hw/rtl/dtc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module dtc_ram #(
	parameter int WIDTH = 63,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/dtc_ctrl.sv]
// Controller of the domino tiling counter: sequences request intake,
// the per-column mask walk, bank swaps and result hand-off. Uses dtc_pkg.
`timescale 1ns / 1ps

module dtc_ctrl (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  dtc_pkg::sts_t sts,
	output dtc_pkg::cmd_t cmd
);
	import dtc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = sts.cols_zero ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (sts.b_zero && sts.a_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last pair of the column is written back in this cycle
				cmd.next_col = 1'b1;
				state_d      = sts.col_last ? ST_DONE : ST_RUN;
			end
			ST_DONE: begin
				if (!sts.out_full) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a drain cycle only follows the end of a column walk
	a_drain_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> $past(state_q == ST_RUN))
		else $error("drain entered without a column walk");

endmodule

[hw/rtl/dtc_datapath.sv]
// Datapath of the domino tiling counter: mask counters, ping-pong count
// banks, saturating accumulator and output register. Uses dtc_pkg, dtc_ram.
`timescale 1ns / 1ps

module dtc_datapath #(
	parameter int MAX_ROWS = dtc_pkg::DTC_MAX_ROWS,
	parameter int MAX_COLS = dtc_pkg::DTC_MAX_COLS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [3:0]                rows,
	input  logic [4:0]                cols,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [dtc_pkg::CNT_W-1:0] tilings,
	output logic                      overflow,
	input  dtc_pkg::cmd_t             cmd,
	output dtc_pkg::sts_t             sts
);
	import dtc_pkg::*;

	localparam int MW    = MAX_ROWS;
	localparam int DEPTH = 1 << MAX_ROWS;
	localparam int CW    = ($clog2(MAX_COLS + 1) > 5) ? $clog2(MAX_COLS + 1) : 5;

	// query registers
	logic [MW-1:0] full_q;
	logic [CW-1:0] w_q;
	logic [CW-1:0] col_q;
	logic [MW-1:0] a_q;
	logic [MW-1:0] b_q;
	logic          sel_q;

	// read stage registers
	logic          v_s1;
	logic          ev_s1;
	logic          first_s1;
	logic          last_s1;
	logic          col0_s1;
	logic          bank_s1;
	logic [MW-1:0] a_s1;

	// accumulation and result
	logic [CNT_W-1:0] acc_q;
	logic [CNT_W-1:0] res_q;
	logic             sat_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] tilings_q;
	logic             overflow_q;

	logic [3:0]    h_new;
	logic [CW-1:0] w_new;
	logic [MW-1:0] full_new;
	logic [MW-1:0] comp;
	logic [MW-1:0] a_inc;
	logic [MW-1:0] b_step;
	logic          first;
	logic          ev;

	logic [CNT_W-1:0] rd0;
	logic [CNT_W-1:0] rd1;
	logic [CNT_W-1:0] rd_sel;
	logic [CNT_W-1:0] base;
	logic [CNT_W-1:0] term;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] acc_nxt;
	logic             we0;
	logic             we1;
	logic             re0;
	logic             re1;

	// clamp the request to the supported board size
	always_comb begin
		h_new = (rows > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : rows;
		w_new = (CW'(cols) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols);
		for (int i = 0; i < MW; i++) begin
			full_new[i] = (4'(i) < h_new);
		end
	end

	// mask pair walk: b runs down the submasks of the complement of a
	assign comp   = full_q & ~a_q;
	assign a_inc  = a_q + MW'(1);
	assign b_step = (b_q - MW'(1)) & comp;
	assign first  = (b_q == comp);
	assign ev     = even_runs(EVEN_W'(a_q | b_q), EVEN_W'(full_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
			w_q    <= '0;
			col_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			sel_q  <= 1'b0;
		end else if (cmd.start) begin
			full_q <= full_new;
			w_q    <= w_new;
			col_q  <= '0;
			a_q    <= '0;
			b_q    <= full_new;
			sel_q  <= 1'b0;
		end else if (cmd.next_col) begin
			col_q <= col_q + CW'(1);
			a_q   <= '0;
			b_q   <= full_q;
			sel_q <= ~sel_q;
		end else if (cmd.issue) begin
			if (b_q == '0) begin
				a_q <= a_inc;
				b_q <= full_q & ~a_inc;
			end else begin
				b_q <= b_step;
			end
		end
	end

	// read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		ev_s1    <= ev;
		first_s1 <= first;
		last_s1  <= (b_q == '0);
		col0_s1  <= (col_q == '0);
		bank_s1  <= sel_q;
		a_s1     <= a_q;
	end

	// count banks: read one, write the other
	assign re0 = cmd.issue & ~sel_q;
	assign re1 = cmd.issue & sel_q;
	assign we0 = v_s1 & last_s1 & bank_s1;
	assign we1 = v_s1 & last_s1 & ~bank_s1;

	dtc_ram #(
		.WIDTH(CNT_W),
		.DEPTH(DEPTH)
	) u_bank0 (
		.clk  (clk),
		.we   (we0),
		.waddr(a_s1),
		.wdata(acc_nxt),
		.re   (re0),
		.raddr(b_q),
		.rdata(rd0)
	);

	dtc_ram #(
		.WIDTH(CNT_W),
		.DEPTH(DEPTH)
	) u_bank1 (
		.clk  (clk),
		.we   (we1),
		.waddr(a_s1),
		.wdata(acc_nxt),
		.re   (re1),
		.raddr(b_q),
		.rdata(rd1)
	);

	// saturating accumulate; first column sees only the empty mask as one
	always_comb begin
		rd_sel = bank_s1 ? rd1 : rd0;
		base   = first_s1 ? '0 : acc_q;
		if (!ev_s1) begin
			term = '0;
		end else if (col0_s1) begin
			term = last_s1 ? CNT_W'(1) : '0;
		end else begin
			term = rd_sel;
		end
		sum     = {1'b0, base} + {1'b0, term};
		acc_nxt = sum[CNT_W] ? SAT_MAX : sum[CNT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			acc_q <= acc_nxt;
		end
		if (cmd.start) begin
			res_q <= CNT_W'(1);
		end else if (v_s1 && last_s1 && (a_s1 == '0)) begin
			res_q <= acc_nxt;
		end
	end

	// sticky saturation flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.start) begin
			sat_q <= 1'b0;
		end else if (v_s1 && sum[CNT_W]) begin
			sat_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			tilings_q  <= sat_q ? SAT_MAX : res_q;
			overflow_q <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign tilings   = tilings_q;
	assign overflow  = overflow_q;

	// status to the controller
	always_comb begin
		sts           = '0;
		sts.cols_zero = (cols == 5'd0);
		sts.b_zero    = (b_q == '0);
		sts.a_last    = (a_q == full_q);
		sts.col_last  = (col_q == (w_q - CW'(1)));
		sts.out_full  = out_valid_q & ~out_ready;
	end

	// a bank is never read and written in the same cycle
	a_bank0_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(we0 && re0))
		else $error("bank 0 read and written together");

	a_bank1_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(we1 && re1))
		else $error("bank 1 read and written together");

	// a held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

endmodule

[bench/tiling_count_checker.sv]
// Checker for the domino tiling counter: watches both channels, works out the
// tiling count of every accepted request and compares it with each result.
// Depends on dtc_pkg for the count width, the saturation limit and the board limits.
`timescale 1ns / 1ps

module tiling_count_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [3:0]                rows,
	input  logic [4:0]                cols,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [dtc_pkg::CNT_W-1:0] tilings,
	input  logic                      overflow,
	output int                        mismatches,
	output int                        counts_waiting
);
	import dtc_pkg::*;

	localparam int MASK_SPAN = 1 << DTC_MAX_ROWS;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             sat;
	} tiling_answer_t;

	tiling_answer_t expected_counts[$];
	tiling_answer_t oldest;

	initial begin
		mismatches     = 0;
		counts_waiting = 0;
	end

	// column-by-column mask walk, every sum saturating below 2^63
	function automatic tiling_answer_t count_tilings(input logic [3:0] height_in,
		input logic [4:0] width_in);
		int height;
		int width;
		int full;
		int comp;
		int a;
		int b;
		int col;
		int run;
		int i;
		bit [63:0] prev_cnt [MASK_SPAN];
		bit [63:0] next_cnt [MASK_SPAN];
		bit even_ok [MASK_SPAN];
		bit [63:0] acc;
		bit [63:0] sum;
		bit saturated;
		tiling_answer_t ans;

		height = (height_in > DTC_MAX_ROWS) ? DTC_MAX_ROWS : int'(height_in);
		width  = (width_in > DTC_MAX_COLS) ? DTC_MAX_COLS : int'(width_in);
		full   = (1 << height) - 1;

		// which column fillings leave only even gaps for vertical dominoes
		for (a = 0; a <= full; a++) begin
			even_ok[a] = 1'b1;
			run = 0;
			for (i = 0; i < height; i++) begin
				if ((a >> i) & 1) begin
					if (run & 1)
						even_ok[a] = 1'b0;
					run = 0;
				end else begin
					run++;
				end
			end
			if (run & 1)
				even_ok[a] = 1'b0;
		end

		for (a = 0; a < MASK_SPAN; a++) begin
			prev_cnt[a] = '0;
			next_cnt[a] = '0;
		end
		prev_cnt[0] = 64'd1;
		saturated   = 1'b0;

		for (col = 0; col < width; col++) begin
			for (a = 0; a <= full; a++) begin
				comp = full & ~a;
				b    = comp;
				acc  = '0;
				// every source mask disjoint from a
				while (1) begin
					if (even_ok[a | b]) begin
						sum = acc + prev_cnt[b];
						if (sum > {1'b0, SAT_MAX}) begin
							saturated = 1'b1;
							acc = {1'b0, SAT_MAX};
						end else begin
							acc = sum;
						end
					end
					if (b == 0)
						break;
					b = (b - 1) & comp;
				end
				next_cnt[a] = acc;
			end
			for (a = 0; a <= full; a++)
				prev_cnt[a] = next_cnt[a];
		end

		ans.sat   = saturated;
		ans.count = saturated ? SAT_MAX : prev_cnt[0][CNT_W-1:0];
		return ans;
	endfunction

	// append one expected answer behind the ones already waiting
	task automatic enqueue_answer(input tiling_answer_t ans);
		expected_counts = {expected_counts, ans};
	endtask

	// results retire the oldest request first, then new requests queue up
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_counts.size() == 0) begin
					$error("result with no request waiting: tilings %0d overflow %0d",
						tilings, overflow);
					mismatches++;
				end else begin
					oldest = expected_counts.pop_front();
					if (tilings !== oldest.count) begin
						$error("tilings: expected %0d, got %0d", oldest.count, tilings);
						mismatches++;
					end
					if (overflow !== oldest.sat) begin
						$error("overflow: expected %0d, got %0d", oldest.sat, overflow);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				enqueue_answer(count_tilings(rows, cols));
			counts_waiting = expected_counts.size();
		end
	end

endmodule

[bench/testbench.sv]
// Top of the domino tiling counter bench: clock, reset, request stimulus with
// bursty timing, a stalling receiver, the timeout and the final verdict.
// Depends on dtc_pkg, domino_tiling_counter_core and tiling_count_checker.
`timescale 1ns / 1ps

module testbench;

	import dtc_pkg::*;

	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN_TAIL  = 16;
	localparam int RANDOM_REQS = 67;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [3:0]       rows = '0;
	logic [4:0]       cols = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [CNT_W-1:0] tilings;
	logic             overflow;

	int mismatches;
	int counts_waiting;
	int cycle_count = 0;
	int burst_left = 0;
	logic hold_req = 1'b0;

	domino_tiling_counter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rows      (rows),
		.cols      (cols),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tilings   (tilings),
		.overflow  (overflow)
	);

	tiling_count_checker checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rows           (rows),
		.cols           (cols),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.tilings        (tilings),
		.overflow       (overflow),
		.mismatches     (mismatches),
		.counts_waiting (counts_waiting)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("domino_tiling_counter_core: mismatch");
			$finish;
		end
	end

	// receiver: one long hold-off on request, otherwise changing stall patterns
	initial begin
		int pattern_kind;
		int pattern_left;
		int duty_phase;
		bit hold_done;
		pattern_kind = 0;
		pattern_left = 0;
		duty_phase   = 0;
		hold_done    = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (pattern_left == 0) begin
				pattern_kind = $urandom_range(0, 3);
				pattern_left = $urandom_range(20, 200);
			end
			pattern_left--;
			duty_phase = (duty_phase + 1) % 3;
			case (pattern_kind)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= (duty_phase == 0);
			endcase
		end
	end

	// offer one request, with a random gap whenever a burst runs out
	task automatic send_request(input logic [3:0] height, input logic [4:0] width);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		rows     <= height;
		cols     <= width;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
	endtask

	initial begin
		int n;
		logic [3:0] height;
		logic [4:0] width;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty boards, odd areas, small known counts
		send_request(4'd0, 5'd0);
		send_request(4'd0, 5'd5);
		send_request(4'd3, 5'd0);
		send_request(4'd15, 5'd0);
		send_request(4'd1, 5'd1);
		send_request(4'd1, 5'd2);
		send_request(4'd2, 5'd1);
		send_request(4'd2, 5'd2);
		send_request(4'd2, 5'd3);
		send_request(4'd3, 5'd4);
		send_request(4'd4, 5'd4);
		send_request(4'd3, 5'd3);
		// widths at and past the limit
		send_request(4'd4, 5'd16);
		send_request(4'd1, 5'd31);
		send_request(4'd2, 5'd31);
		send_request(4'd2, 5'd17);
		// tall boards, height past the limit
		send_request(4'd8, 5'd1);
		send_request(4'd8, 5'd8);
		send_request(4'd12, 5'd1);
		// largest board, count saturates; then an empty board at the height limit
		send_request(4'd15, 5'd31);
		send_request(4'd11, 5'd0);

		// long receiver hold-off while tiny requests keep coming
		hold_req <= 1'b1;
		for (n = 0; n < 12; n++) begin
			height = 4'($urandom_range(0, 2));
			width  = 5'($urandom_range(0, 3));
			send_request(height, width);
		end

		// random boards, mostly short so the run stays bounded
		for (n = 0; n < RANDOM_REQS; n++) begin
			if ($urandom_range(0, 9) != 0) begin
				height = 4'($urandom_range(0, 6));
				width  = 5'($urandom_range(0, 31));
			end else begin
				height = 4'($urandom_range(7, 15));
				width  = (height <= 9) ? 5'($urandom_range(0, 2)) : 5'd0;
			end
			send_request(height, width);
		end
		in_valid <= 1'b0;

		// let the checker queue the last request, drain, then idle for a tail
		@(posedge clk);
		while (counts_waiting != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		if (mismatches == 0)
			$display("domino_tiling_counter_core: match");
		else
			$display("domino_tiling_counter_core: mismatch");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/dtc_pkg.sv
hw/rtl/dtc_ram.sv
hw/rtl/dtc_ctrl.sv
hw/rtl/dtc_datapath.sv
hw/rtl/domino_tiling_counter_core.sv
bench/tiling_count_checker.sv
bench/testbench.sv
